// ===== rtl/circumcenter_three_points_defines.svh =====
// Assertion macros used by the circumcenter top-level design file.
`ifndef CIRCUMCENTER_THREE_POINTS_DEFINES_SVH
`define CIRCUMCENTER_THREE_POINTS_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CCP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circumcenter check failed");
`define CCP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circumcenter check failed");
`else
`define CCP_ASSERT_IMPL(lbl, ante, cons)
`define CCP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/ccp_pkg.sv =====
// Package: widths, status codes and interface structs of the circumcenter block.
package ccp_pkg;

    localparam int FRAC_BITS = 8;
    localparam int CW        = 16;
    localparam int DW1       = CW + 1;
    localparam int PW        = 2 * DW1;
    localparam int SQW       = PW + 1;
    localparam int DENW      = PW + 2;
    localparam int MW        = DW1 + SQW;
    localparam int NW        = MW + 4;
    localparam int QW        = 32;
    localparam int DIVW      = NW + FRAC_BITS;
    localparam int HIW       = DIVW - QW;
    localparam int DIV_LAT   = QW + 1;
    localparam int PRE_ST    = 5;
    localparam int IN_W      = 6 * CW;
    localparam int OUT_W     = 72;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_COLL = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef struct packed {
        logic [NW-1:0]   num;
        logic [DENW-1:0] den;
        logic            neg;
    } div_in_t;

    typedef struct packed {
        logic [QW-1:0] quot;
        logic          ovf;
        logic          neg;
    } div_out_t;

endpackage

// ===== rtl/ccp_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, overflow flag up front.
module ccp_div (
    input  logic               clk,
    input  logic               en,
    input  ccp_pkg::div_in_t   din,
    output ccp_pkg::div_out_t  dout
);

    localparam int CMPW = ccp_pkg::HIW + ccp_pkg::DENW;

    logic [ccp_pkg::DENW-1:0] rem_reg  [0:ccp_pkg::QW];
    logic [ccp_pkg::QW-1:0]   rest_reg [0:ccp_pkg::QW];
    logic [ccp_pkg::QW-1:0]   quot_reg [0:ccp_pkg::QW];
    logic [ccp_pkg::DENW-1:0] den_reg  [0:ccp_pkg::QW];
    logic                     neg_reg  [0:ccp_pkg::QW];
    logic                     ovf_reg  [0:ccp_pkg::QW];

    logic [ccp_pkg::DIVW-1:0] dividend;
    logic [ccp_pkg::HIW-1:0]  hi;
    logic                     ovf_next;

    logic [ccp_pkg::DENW:0]   trial [0:ccp_pkg::QW-1];
    logic [ccp_pkg::DENW:0]   diff  [0:ccp_pkg::QW-1];
    logic                     ge    [0:ccp_pkg::QW-1];

    always_comb
    begin
        dividend = {din.num, {ccp_pkg::FRAC_BITS{1'b0}}};
        hi       = dividend[ccp_pkg::DIVW-1:ccp_pkg::QW];
        ovf_next = (CMPW'(hi) >= CMPW'(din.den));
    end

    always_comb
    begin
        for (int s = 0; s < ccp_pkg::QW; s++)
        begin
            trial[s] = {rem_reg[s], rest_reg[s][ccp_pkg::QW-1]};
            diff[s]  = trial[s] - {1'b0, den_reg[s]};
            ge[s]    = (trial[s] >= {1'b0, den_reg[s]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= ccp_pkg::DENW'(hi);
            rest_reg[0] <= dividend[ccp_pkg::QW-1:0];
            quot_reg[0] <= '0;
            den_reg[0]  <= din.den;
            neg_reg[0]  <= din.neg;
            ovf_reg[0]  <= ovf_next;
            for (int s = 0; s < ccp_pkg::QW; s++)
            begin
                rem_reg[s+1]  <= ge[s] ? diff[s][ccp_pkg::DENW-1:0]
                                       : trial[s][ccp_pkg::DENW-1:0];
                rest_reg[s+1] <= {rest_reg[s][ccp_pkg::QW-2:0], 1'b0};
                quot_reg[s+1] <= {quot_reg[s][ccp_pkg::QW-2:0], ge[s]};
                den_reg[s+1]  <= den_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                ovf_reg[s+1]  <= ovf_reg[s];
            end
        end
    end

    assign dout.quot = quot_reg[ccp_pkg::QW];
    assign dout.ovf  = ovf_reg[ccp_pkg::QW];
    assign dout.neg  = neg_reg[ccp_pkg::QW];

endmodule

// ===== rtl/circumcenter_three_points.sv =====
// Top level: circumcenter of three integer points, fully pipelined.
// Request to result: 5 arithmetic stages, 33 divider stages, then the output register.
// Throughput: one request per cycle unless the output stalls; the 32 quotient bits each take one divider stage.
// A stalled output holds the pipeline; a bubble ahead of the output is still filled.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers keep no reset.
`include "circumcenter_three_points_defines.svh"

module circumcenter_three_points (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y (16 bits each)
    input  logic [ccp_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // center_x (32), center_y (32), status (2), zero fill (6)
    output logic [ccp_pkg::OUT_W-1:0]  m_tdata
);

    localparam logic [ccp_pkg::QW-1:0] LIM_POS = {1'b0, {(ccp_pkg::QW-1){1'b1}}};
    localparam logic [ccp_pkg::QW-1:0] LIM_NEG = {1'b1, {(ccp_pkg::QW-1){1'b0}}};

    logic en;
    logic last_vld;
    logic load;

    logic pv_reg   [0:ccp_pkg::PRE_ST-1];
    logic dv_reg   [0:ccp_pkg::DIV_LAT-1];
    logic coll_reg [0:ccp_pkg::DIV_LAT-1];

    logic                           m_tvalid_reg;
    logic [ccp_pkg::OUT_W-1:0]      m_tdata_reg;
    logic [ccp_pkg::OUT_W-1:0]      m_tdata_next;

    logic signed [ccp_pkg::CW-1:0]  first_x, first_y, second_x, second_y, third_x, third_y;

    logic signed [ccp_pkg::CW-1:0]  ax1_reg, ay1_reg;
    logic signed [ccp_pkg::DW1-1:0] bx1_reg, by1_reg, cx1_reg, cy1_reg;

    logic signed [ccp_pkg::CW-1:0]  ax2_reg, ay2_reg;
    logic signed [ccp_pkg::DW1-1:0] bx2_reg, by2_reg, cx2_reg, cy2_reg;
    logic signed [ccp_pkg::PW-1:0]  pbb_reg, pby_reg, pcx_reg, pcy_reg, pbc_reg, pcb_reg;

    logic signed [ccp_pkg::CW-1:0]  ax3_reg, ay3_reg;
    logic signed [ccp_pkg::DW1-1:0] bx3_reg, by3_reg, cx3_reg, cy3_reg;
    logic signed [ccp_pkg::SQW-1:0] bsq_reg, csq_reg;
    logic signed [ccp_pkg::DENW-1:0] den3_reg;

    logic signed [ccp_pkg::MW-1:0]  m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic signed [ccp_pkg::MW-1:0]  m1_next, m2_next, m3_next, m4_next, m5_next, m6_next;
    logic signed [ccp_pkg::DENW-1:0] den4_reg;

    logic signed [ccp_pkg::NW-1:0]  nx_reg, ny_reg;
    logic signed [ccp_pkg::DENW-1:0] den5_reg;

    ccp_pkg::div_in_t  dinx, diny;
    ccp_pkg::div_out_t doutx, douty;

    logic [ccp_pkg::QW-1:0] limx, limy, mx, my, rx, ry;
    logic                   satx, saty, coll;

    assign first_x  = $signed(s_tdata[15:0]);
    assign first_y  = $signed(s_tdata[31:16]);
    assign second_x = $signed(s_tdata[47:32]);
    assign second_y = $signed(s_tdata[63:48]);
    assign third_x  = $signed(s_tdata[79:64]);
    assign third_y  = $signed(s_tdata[95:80]);

    assign last_vld = dv_reg[ccp_pkg::DIV_LAT-1];
    assign load     = !m_tvalid_reg || m_tready;
    assign en       = load || !last_vld;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ccp_pkg::PRE_ST; i++)
            begin
                pv_reg[i] <= 1'b0;
            end
            for (int i = 0; i < ccp_pkg::DIV_LAT; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                pv_reg[0] <= s_tvalid;
                for (int i = 1; i < ccp_pkg::PRE_ST; i++)
                begin
                    pv_reg[i] <= pv_reg[i-1];
                end
                dv_reg[0] <= pv_reg[ccp_pkg::PRE_ST-1];
                for (int i = 1; i < ccp_pkg::DIV_LAT; i++)
                begin
                    dv_reg[i] <= dv_reg[i-1];
                end
            end
            if (load)
            begin
                m_tvalid_reg <= last_vld;
            end
        end
    end

    assign m1_next = ax3_reg * den3_reg;
    assign m2_next = ay3_reg * den3_reg;
    assign m3_next = cy3_reg * bsq_reg;
    assign m4_next = by3_reg * csq_reg;
    assign m5_next = bx3_reg * csq_reg;
    assign m6_next = cx3_reg * bsq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg <= first_x;
            ay1_reg <= first_y;
            bx1_reg <= ccp_pkg::DW1'(second_x) - ccp_pkg::DW1'(first_x);
            by1_reg <= ccp_pkg::DW1'(second_y) - ccp_pkg::DW1'(first_y);
            cx1_reg <= ccp_pkg::DW1'(third_x) - ccp_pkg::DW1'(first_x);
            cy1_reg <= ccp_pkg::DW1'(third_y) - ccp_pkg::DW1'(first_y);

            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            bx2_reg <= bx1_reg;
            by2_reg <= by1_reg;
            cx2_reg <= cx1_reg;
            cy2_reg <= cy1_reg;
            pbb_reg <= bx1_reg * bx1_reg;
            pby_reg <= by1_reg * by1_reg;
            pcx_reg <= cx1_reg * cx1_reg;
            pcy_reg <= cy1_reg * cy1_reg;
            pbc_reg <= bx1_reg * cy1_reg;
            pcb_reg <= by1_reg * cx1_reg;

            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            bx3_reg  <= bx2_reg;
            by3_reg  <= by2_reg;
            cx3_reg  <= cx2_reg;
            cy3_reg  <= cy2_reg;
            bsq_reg  <= ccp_pkg::SQW'(pbb_reg) + ccp_pkg::SQW'(pby_reg);
            csq_reg  <= ccp_pkg::SQW'(pcx_reg) + ccp_pkg::SQW'(pcy_reg);
            den3_reg <= (ccp_pkg::DENW'(pbc_reg) - ccp_pkg::DENW'(pcb_reg)) <<< 1;

            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
            m3_reg   <= m3_next;
            m4_reg   <= m4_next;
            m5_reg   <= m5_next;
            m6_reg   <= m6_next;
            den4_reg <= den3_reg;

            nx_reg   <= ccp_pkg::NW'(m1_reg) + ccp_pkg::NW'(m3_reg) - ccp_pkg::NW'(m4_reg);
            ny_reg   <= ccp_pkg::NW'(m2_reg) + ccp_pkg::NW'(m5_reg) - ccp_pkg::NW'(m6_reg);
            den5_reg <= den4_reg;

            coll_reg[0] <= (den5_reg == '0);
            for (int i = 1; i < ccp_pkg::DIV_LAT; i++)
            begin
                coll_reg[i] <= coll_reg[i-1];
            end
        end
        if (load)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_comb
    begin
        dinx.num = nx_reg[ccp_pkg::NW-1] ? ccp_pkg::NW'(-nx_reg) : ccp_pkg::NW'(nx_reg);
        diny.num = ny_reg[ccp_pkg::NW-1] ? ccp_pkg::NW'(-ny_reg) : ccp_pkg::NW'(ny_reg);
        dinx.den = den5_reg[ccp_pkg::DENW-1] ? ccp_pkg::DENW'(-den5_reg)
                                              : ccp_pkg::DENW'(den5_reg);
        diny.den = dinx.den;
        dinx.neg = nx_reg[ccp_pkg::NW-1] ^ den5_reg[ccp_pkg::DENW-1];
        diny.neg = ny_reg[ccp_pkg::NW-1] ^ den5_reg[ccp_pkg::DENW-1];
    end

    ccp_div u_div_x (
        .clk  (clk),
        .en   (en),
        .din  (dinx),
        .dout (doutx)
    );

    ccp_div u_div_y (
        .clk  (clk),
        .en   (en),
        .din  (diny),
        .dout (douty)
    );

    always_comb
    begin
        coll = coll_reg[ccp_pkg::DIV_LAT-1];
        limx = doutx.neg ? LIM_NEG : LIM_POS;
        limy = douty.neg ? LIM_NEG : LIM_POS;
        satx = doutx.ovf || (doutx.quot > limx);
        saty = douty.ovf || (douty.quot > limy);
        mx   = satx ? limx : doutx.quot;
        my   = saty ? limy : douty.quot;
        rx   = doutx.neg ? (~mx + 1'b1) : mx;
        ry   = douty.neg ? (~my + 1'b1) : my;
        m_tdata_next = '0;
        if (coll)
        begin
            m_tdata_next[65:64] = ccp_pkg::ST_COLL;
        end
        else
        begin
            m_tdata_next[31:0]  = rx;
            m_tdata_next[63:32] = ry;
            m_tdata_next[65:64] = (satx || saty) ? ccp_pkg::ST_SAT : ccp_pkg::ST_OK;
        end
    end

    `CCP_ASSERT_IMPL(a_coll_zero, m_tvalid_reg && (m_tdata_reg[65:64] == ccp_pkg::ST_COLL), m_tdata_reg[63:0] == '0)
    `CCP_ASSERT_IMPL(a_sat_clamped, m_tvalid_reg && (m_tdata_reg[65:64] == ccp_pkg::ST_SAT), (m_tdata_reg[31:0] == LIM_POS) || (m_tdata_reg[31:0] == LIM_NEG) || (m_tdata_reg[63:32] == LIM_POS) || (m_tdata_reg[63:32] == LIM_NEG))
    `CCP_ASSERT_NEXT(a_stall_hold, !en, $stable(last_vld) && $stable(pv_reg[0]))

endmodule
